// File: hw/rtl/midi_last_note_priority_tone_assert.svh
// Assertion macros used by the checker file of the MIDI tone block.
`ifndef MIDI_LAST_NOTE_PRIORITY_TONE_ASSERT_SVH
`define MIDI_LAST_NOTE_PRIORITY_TONE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLNPT_ASSERT_IMPL(name, clock, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLNPT_ASSERT_NEXT(name, clock, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/mlnpt_pkg.sv
// Shared constants, types and the note-to-period function of the MIDI tone block.
package mlnpt_pkg;

	localparam int STACK_DEPTH = 5;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int HELD_W = 3;
	localparam int PERIOD_W = 16;
	localparam int NOTE_W = 7;
	localparam int CHAN_W = 4;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int OCT_STEP = 12;

	localparam logic [0:0] REG_LISTEN_CHANNEL = 1'b0;

	localparam logic [PERIOD_W-1:0] OCTAVE_TABLE [OCT_STEP] = '{
		16'd61156, 16'd57723, 16'd54484, 16'd51424, 16'd48539, 16'd45817,
		16'd43245, 16'd40816, 16'd38527, 16'd36364, 16'd34322, 16'd32396
	};

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = OCTAVE_TABLE[0];

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic store_first;
		logic push;
		logic clr_idx;
		logic step;
		logic remove;
		logic rd_top;
		logic load_top;
		logic emit;
	} mlnpt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic match;
		logic idx_end;
		logic out_free;
	} mlnpt_sts_t;

	// The octave is found by ten independent compares; the remainder then
	// picks the base period, which is halved once per octave.
	function automatic logic [PERIOD_W-1:0] period_of(input logic [NOTE_W-1:0] note);
		logic [3:0] oct;
		logic [NOTE_W-1:0] rem;
		oct = '0;
		for (int k = 1; k <= 10; k++) begin
			if (note >= NOTE_W'(OCT_STEP * k))
				oct = 4'(k);
		end
		rem = note - NOTE_W'(OCT_STEP * oct);
		return OCTAVE_TABLE[rem[3:0]] >> oct;
	endfunction

endpackage

// File: hw/rtl/mlnpt_ctrl.sv
// Controller of the MIDI tone block: byte parser and stack sequencer.
module mlnpt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [mlnpt_pkg::CHAN_W-1:0] listen_channel,
	input  mlnpt_pkg::mlnpt_sts_t     sts,
	output mlnpt_pkg::mlnpt_cmd_t     cmd
);
	import mlnpt_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PARSE  = 3'd1;
	localparam logic [2:0] ST_PUSH   = 3'd2;
	localparam logic [2:0] ST_SEARCH = 3'd3;
	localparam logic [2:0] ST_REMOVE = 3'd4;
	localparam logic [2:0] ST_TOP    = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ON   = 2'd1;
	localparam logic [1:0] KIND_OFF  = 2'd2;
	localparam logic [1:0] KIND_CC   = 2'd3;

	localparam logic [3:0] HI_OFF = 4'h8;
	localparam logic [3:0] HI_ON  = 4'h9;
	localparam logic [3:0] HI_CC  = 4'hB;

	localparam logic [7:0] RT_SENSE = 8'hFE;
	localparam logic [7:0] RT_RESET = 8'hFF;

	logic [2:0] state_q, state_d;
	logic [1:0] kind_q, kind_d;
	logic       first_seen_q, first_seen_d;
	logic       mine;

	assign in_stall = (state_q != ST_IDLE);
	assign mine = (sts.rx_byte[3:0] == listen_channel);

	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		first_seen_d = first_seen_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_PARSE;
				end
			end
			ST_PARSE: begin
				state_d = ST_IDLE;
				if (sts.rx_byte == RT_SENSE || sts.rx_byte == RT_RESET) begin
					state_d = ST_IDLE;
				end else if (sts.rx_byte[7]) begin
					first_seen_d = 1'b0;
					unique case (sts.rx_byte[7:4])
						HI_ON:   kind_d = mine ? KIND_ON : KIND_NONE;
						HI_OFF:  kind_d = mine ? KIND_OFF : KIND_NONE;
						HI_CC:   kind_d = mine ? KIND_CC : KIND_NONE;
						default: kind_d = KIND_NONE;
					endcase
				end else if (kind_q == KIND_NONE) begin
					state_d = ST_IDLE;
				end else if (!first_seen_q) begin
					cmd.store_first = 1'b1;
					first_seen_d = 1'b1;
				end else begin
					first_seen_d = 1'b0;
					if (kind_q == KIND_ON && sts.rx_byte != 8'd0) begin
						state_d = ST_PUSH;
					end else if (kind_q == KIND_ON || kind_q == KIND_OFF) begin
						cmd.clr_idx = 1'b1;
						state_d = ST_SEARCH;
					end
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d = ST_EMIT;
			end
			ST_SEARCH: begin
				if (sts.match) begin
					state_d = ST_REMOVE;
				end else if (sts.idx_end) begin
					state_d = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_REMOVE: begin
				cmd.remove = 1'b1;
				state_d = ST_TOP;
			end
			ST_TOP: begin
				cmd.rd_top = 1'b1;
				cmd.load_top = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= KIND_NONE;
			first_seen_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
			first_seen_q <= first_seen_d;
		end
	end

endmodule

// File: hw/rtl/mlnpt_dp.sv
// Datapath of the MIDI tone block: held-note stack, period and output register.
module mlnpt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [7:0]                    midi_byte,
	input  mlnpt_pkg::mlnpt_cmd_t         cmd,
	output mlnpt_pkg::mlnpt_sts_t         sts,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          gate_on,
	output logic [mlnpt_pkg::PERIOD_W-1:0] tone_period,
	output logic [mlnpt_pkg::HELD_W-1:0]  held_count
);
	import mlnpt_pkg::*;

	logic [7:0]          byte_q;
	logic [NOTE_W-1:0]   note_q;
	logic [NOTE_W-1:0]   held_q [STACK_DEPTH];
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    idx_q;
	logic [PERIOD_W-1:0] period_q;
	logic                out_valid_q;
	logic                gate_q;
	logic [PERIOD_W-1:0] out_period_q;
	logic [HELD_W-1:0]   out_count_q;
	logic [CNT_W-1:0]    rd_addr;
	logic [NOTE_W-1:0]   rd_data;

	// Single read port: the search index, or the top of the stack.
	assign rd_addr = cmd.rd_top ? (cnt_q - CNT_W'(1)) : idx_q;

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			if (rd_addr == CNT_W'(i))
				rd_data = held_q[i];
		end
	end

	assign sts.rx_byte = byte_q;
	assign sts.idx_end = (idx_q >= cnt_q);
	assign sts.match = (idx_q < cnt_q) && (rd_data == note_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.capture)
			byte_q <= midi_byte;
		if (cmd.store_first)
			note_q <= byte_q[NOTE_W-1:0];
		if (cmd.push) begin
			if (cnt_q == CNT_W'(STACK_DEPTH)) begin
				for (int i = 0; i < STACK_DEPTH - 1; i++)
					held_q[i] <= held_q[i+1];
				held_q[STACK_DEPTH-1] <= note_q;
			end else begin
				for (int i = 0; i < STACK_DEPTH; i++) begin
					if (cnt_q == CNT_W'(i))
						held_q[i] <= note_q;
				end
			end
		end
		if (cmd.remove) begin
			for (int i = 0; i < STACK_DEPTH - 1; i++) begin
				if (CNT_W'(i) >= idx_q && CNT_W'(i + 1) < cnt_q)
					held_q[i] <= held_q[i+1];
			end
		end
		if (cmd.emit) begin
			gate_q <= (cnt_q != '0);
			out_period_q <= period_q;
			out_count_q <= HELD_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			period_q <= PERIOD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				if (cnt_q != CNT_W'(STACK_DEPTH))
					cnt_q <= cnt_q + CNT_W'(1);
				period_q <= period_of(note_q);
			end
			if (cmd.remove)
				cnt_q <= cnt_q - CNT_W'(1);
			if (cmd.load_top && cnt_q != '0)
				period_q <= period_of(rd_data);
			if (cmd.clr_idx)
				idx_q <= '0;
			else if (cmd.step)
				idx_q <= idx_q + CNT_W'(1);
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign gate_on = gate_q;
	assign tone_period = out_period_q;
	assign held_count = out_count_q;

endmodule

// File: hw/rtl/midi_last_note_priority_tone.sv
// Top level of the MIDI last-note-priority tone selector.
// This block takes MIDI bytes one request at a time and keeps a stack of the
// notes held on one channel, so that the newest held note always sounds. The
// real-time bytes 0xFE and 0xFF are dropped. Note-on, note-off and control
// change on the channel set in listen_channel (register 0, byte address 0)
// become the running status; any other status byte halts parsing until one of
// those arrives. A result request (gate_on, tone_period, held_count) comes out
// only after a push, or after a release that finds its note in the stack. The
// tone period is the octave table value for the note's pitch class, halved once
// per octave. A byte with no result is first accepted and then decoded. A
// release searches the stack one entry per cycle. A finished result waits in an
// output register, so the next byte can be accepted while the result is still
// stalled; only a later result waits for it.
module midi_last_note_priority_tone (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mlnpt_pkg::ADDR_W-1:0]  paddr,
	input  logic [mlnpt_pkg::DATA_W-1:0]  pwdata,
	output logic [mlnpt_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    midi_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          gate_on,
	output logic [mlnpt_pkg::PERIOD_W-1:0] tone_period,
	output logic [mlnpt_pkg::HELD_W-1:0]  held_count
);
	import mlnpt_pkg::*;

	logic [CHAN_W-1:0] listen_channel_q;
	logic              reg_hit;
	mlnpt_cmd_t        cmd;
	mlnpt_sts_t        sts;

	// The register file holds a single register; bit 2 of the address picks
	// the register index, the low bits are the byte offset.
	assign pready = 1'b1;
	assign reg_hit = (paddr[2:2] == REG_LISTEN_CHANNEL);
	assign prdata = reg_hit ? DATA_W'(listen_channel_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_channel_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			listen_channel_q <= pwdata[CHAN_W-1:0];
		end
	end

	// The controller owns the running status; the datapath owns the stack.
	mlnpt_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.listen_channel (listen_channel_q),
		.sts            (sts),
		.cmd            (cmd)
	);

	mlnpt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.midi_byte   (midi_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.gate_on     (gate_on),
		.tone_period (tone_period),
		.held_count  (held_count)
	);

endmodule

// File: hw/rtl/mlnpt_checker.sv
// Port-level checker of the MIDI tone block and its bind to the top level.
`include "midi_last_note_priority_tone_assert.svh"

module mlnpt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          gate_on,
	input logic [mlnpt_pkg::PERIOD_W-1:0] tone_period,
	input logic [mlnpt_pkg::HELD_W-1:0]  held_count
);
	import mlnpt_pkg::*;

	// The stack never reports more notes than it can hold.
	`MLNPT_ASSERT_IMPL(a_count_range, clk, arst_n, out_valid, held_count <= STACK_DEPTH, "held count beyond stack depth")

	// A note sounds exactly when at least one note is held.
	`MLNPT_ASSERT_IMPL(a_gate_matches_count, clk, arst_n, out_valid, gate_on == (held_count != '0), "gate does not match held count")

	// Each accepted byte is decoded before the next byte is accepted.
	`MLNPT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "byte accepted in back-to-back cycles")

	// A stalled result stays in place.
	`MLNPT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(gate_on) && $stable(tone_period) && $stable(held_count), "stalled result changed")

endmodule

bind midi_last_note_priority_tone mlnpt_checker u_mlnpt_checker (.*);
